// ===== src/assert_macros.svh =====
// Assertion macros shared by the window generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/csw_pkg.sv =====
// Constants, types and cosine table builder for the cosine-sum window generator
package csw_pkg;

  localparam int INDEX_BITS      = 16;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int FRAC_BITS       = 16;

  localparam int LEN_BITS    = 17;
  localparam int COEF_BITS   = 18;
  localparam int WEIGHT_BITS = 22;
  localparam int DATA_BITS   = 32;
  localparam int NUM_COEFS   = 5;
  localparam int NUM_LANES   = 4;

  localparam int ROM_ADDR_BITS = $clog2(COS_TABLE_DEPTH);
  localparam int PHASE_BITS    = ROM_ADDR_BITS + 2;
  localparam int COS_BITS      = FRAC_BITS + 1;
  localparam int CSIG_BITS     = COS_BITS + 1;

  localparam int DEN_BITS     = LEN_BITS + 1;
  localparam int DIV_NEED     = INDEX_BITS + PHASE_BITS + 4;
  localparam int DIV_STAGES   = (DIV_NEED + 1) / 2;
  localparam int DIV_NUM_BITS = 2 * DIV_STAGES;

  localparam int PROD_BITS = COEF_BITS + 1 + CSIG_BITS;
  localparam int SUM_BITS  = PROD_BITS + 3;

  localparam int STG_IN     = 0;
  localparam int STG_ROM    = DIV_STAGES + 1;
  localparam int STG_COS    = DIV_STAGES + 2;
  localparam int STG_PROD   = DIV_STAGES + 3;
  localparam int STG_SUM    = DIV_STAGES + 4;
  localparam int NUM_STAGES = DIV_STAGES + 5;

  localparam int PADDR_BITS = $clog2(NUM_COEFS + 1) + 2;

  localparam logic [LEN_BITS-1:0]  LEN_RESET   = LEN_BITS'(1024);
  localparam logic [COEF_BITS-1:0] COEF0_RESET = COEF_BITS'(32768);
  localparam logic [COEF_BITS-1:0] COEF1_RESET = COEF_BITS'(32768);

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_COEF0  = 3'd1,
    REG_COEF1  = 3'd2,
    REG_COEF2  = 3'd3,
    REG_COEF3  = 3'd4,
    REG_COEF4  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic                  beyond;
    logic                  short_len;
  } side_t;

  typedef struct packed {
    logic [DEN_BITS-1:0]     rem;
    logic [DIV_NUM_BITS-1:0] num;
    logic [PHASE_BITS-1:0]   quo;
  } div_state_t;

  typedef logic [COS_BITS-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // quarter-wave cosine, Q1.FRAC_BITS, from a Q30 Taylor series
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t        rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned m64;
    longint          s;
    for (int m = 0; m < COS_TABLE_DEPTH; m++) begin
      m64 = longint'(m);
      x  = (m64 * PI_HALF_Q30 + longint'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      s  = longint'(t);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        t = (t * x2) >> 30;
        t = t / TAYLOR_DIV[k-1];
        if (k % 2 == 1) begin
          s = s - longint'(t);
        end else begin
          s = s + longint'(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      rom[m] = COS_BITS'((longint'(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

endpackage

// ===== src/csw_if.sv =====
// Valid/ready channel interfaces for sample indices and window weights
interface csw_index_if;
  import csw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sample_index;
  modport source (output valid, sample_index, input ready);
  modport sink (input valid, sample_index, output ready);
endinterface

interface csw_weight_if;
  import csw_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic                          index_beyond_length;
  logic [INDEX_BITS-1:0]         echo_index;
  modport source (output valid, weight, index_beyond_length, echo_index, input ready);
  modport sink (input valid, weight, index_beyond_length, echo_index, output ready);
endinterface

// ===== src/csw_phase_div.sv =====
// Pipelined restoring divider, two quotient bits per stage, four lanes sharing one divisor
`include "assert_macros.svh"
module csw_phase_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [csw_pkg::DIV_STAGES-1:0]       stage_valid,
  input  logic [csw_pkg::DIV_NUM_BITS-1:0]     num [csw_pkg::NUM_LANES],
  input  logic [csw_pkg::DEN_BITS-1:0]         den,
  output logic [csw_pkg::PHASE_BITS-1:0]       phase [csw_pkg::NUM_LANES]
);
  import csw_pkg::*;

  div_state_t st [DIV_STAGES][NUM_LANES];

  function automatic div_state_t div_step(div_state_t s, logic [DEN_BITS-1:0] d);
    div_state_t          r;
    logic [DEN_BITS:0]   t;
    r = s;
    for (int j = 0; j < 2; j++) begin
      t     = {r.rem, r.num[DIV_NUM_BITS-1]};
      r.num = r.num << 1;
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[PHASE_BITS-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[PHASE_BITS-2:0], 1'b0};
      end
      r.rem = t[DEN_BITS-1:0];
    end
    return r;
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      div_state_t src;
      if (s == 0) begin : g_first
        assign src = '{rem: '0, num: num[k], quo: '0};
      end else begin : g_next
        assign src = st[s-1][k];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          st[s][k] <= div_step(src, den);
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_out
    assign phase[k] = st[DIV_STAGES-1][k].quo;
  end

  `CSW_ASSERT_IMPLIES(a_rem_below_den, clk, rst,
    stage_valid[DIV_STAGES-1] && (den != '0), st[DIV_STAGES-1][0].rem < den)
endmodule

// ===== src/csw_cos_rom.sv =====
// Quarter-wave cosine lookup with quadrant folding, registered read
module csw_cos_rom (
  input  logic                            clk,
  input  logic                            en,
  input  logic [csw_pkg::PHASE_BITS-1:0]  phase,
  output logic [csw_pkg::COS_BITS-1:0]    mag,
  output logic                            zero,
  output logic                            neg
);
  import csw_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  logic [1:0]               quad;
  logic [ROM_ADDR_BITS-1:0] ofs;
  logic [ROM_ADDR_BITS-1:0] addr;

  assign quad = phase[PHASE_BITS-1:PHASE_BITS-2];
  assign ofs  = phase[ROM_ADDR_BITS-1:0];
  // odd quadrants read the mirrored entry; depth minus zero falls off the table
  assign addr = quad[0] ? ROM_ADDR_BITS'(-ofs) : ofs;

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= COS_ROM[addr];
      zero <= quad[0] && (ofs == '0);
      neg  <= quad[1] ^ quad[0];
    end
  end
endmodule

// ===== src/csw_weight_sum.sv =====
// Signed cosine, coefficient products and weighted sum stages
module csw_weight_sum (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [csw_pkg::COS_BITS-1:0]         mag [csw_pkg::NUM_LANES],
  input  logic [csw_pkg::NUM_LANES-1:0]        zero,
  input  logic [csw_pkg::NUM_LANES-1:0]        neg,
  input  logic                                 short_len,
  input  logic [csw_pkg::COEF_BITS-1:0]        coef [csw_pkg::NUM_COEFS],
  output logic signed [csw_pkg::SUM_BITS-1:0]  sum
);
  import csw_pkg::*;

  localparam logic signed [CSIG_BITS-1:0] COS_ONE  = CSIG_BITS'(1) << FRAC_BITS;
  localparam logic signed [SUM_BITS-1:0]  HALF_LSB = SUM_BITS'(1) << (FRAC_BITS - 1);

  logic signed [CSIG_BITS-1:0] cosv [NUM_LANES];
  logic signed [PROD_BITS-1:0] prod [NUM_LANES];
  logic signed [SUM_BITS-1:0]  base;
  logic signed [SUM_BITS-1:0]  acc;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic signed [CSIG_BITS-1:0] smag;
    logic signed [PROD_BITS-1:0] cf;
    assign smag = $signed({1'b0, mag[k]});
    assign cf   = $signed({{(PROD_BITS-COEF_BITS){1'b0}}, coef[k+1]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (short_len) begin
          cosv[k] <= COS_ONE;
        end else if (zero[k]) begin
          cosv[k] <= '0;
        end else if (neg[k]) begin
          cosv[k] <= -smag;
        end else begin
          cosv[k] <= smag;
        end
        prod[k] <= cf * PROD_BITS'(cosv[k]);
      end
    end
  end

  assign base = $signed({{(SUM_BITS-COEF_BITS){1'b0}}, coef[0]}) <<< FRAC_BITS;
  assign acc  = base - SUM_BITS'(prod[0]) + SUM_BITS'(prod[1])
              - SUM_BITS'(prod[2]) + SUM_BITS'(prod[3]) + HALF_LSB;

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= acc;
    end
  end
endmodule

// ===== src/cosine_sum_window_generator.sv =====
// Five-term cosine-sum window generator: top level with config registers
// Usage:
//   index_ch carries one sample index per word; weight_ch returns one word per
//   index holding the Q5.16 window weight, an at-or-past-length flag and the
//   index itself, in order. Both channels use valid/ready.
//   The APB port holds window length and coefficients a0..a4 at byte address
//   4*i; change them only while no index is in flight.
// Throughput: one index per cycle unless stalled; the phase divider is a 16-stage pipeline
//   at two quotient bits per stage, followed by table read, cosine sign,
//   multiply and sum stages.
// Reset: config returns to a Hann window of 1024 points, all in-flight words
//   are dropped.
// Stall: a held result sits in the output register; the pipeline takes indices while
//   its last stage is free or can move on, and stops as a whole when it is not.
`include "assert_macros.svh"
module cosine_sum_window_generator (
  input  logic                            clk,
  input  logic                            rst,
  csw_index_if.sink                       index_ch,
  csw_weight_if.source                    weight_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csw_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [csw_pkg::DATA_BITS-1:0]   pwdata,
  output logic [csw_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);
  import csw_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  logic [LEN_BITS-1:0]  window_length;
  logic [COEF_BITS-1:0] coef [NUM_COEFS];
  reg_idx_t             reg_sel;
  logic                 cfg_write;

  logic [NUM_STAGES-1:0]   v;
  side_t                   side_pipe [NUM_STAGES];
  logic                    en;
  logic                    out_load;
  logic [LEN_BITS-1:0]     len_less_one;
  logic [DEN_BITS-1:0]     den;
  logic [DIV_NUM_BITS-1:0] num_in [NUM_LANES];
  logic [DIV_NUM_BITS-1:0] num    [NUM_LANES];
  logic [PHASE_BITS-1:0]   phase  [NUM_LANES];
  logic [COS_BITS-1:0]     mag    [NUM_LANES];
  logic [NUM_LANES-1:0]    zero;
  logic [NUM_LANES-1:0]    neg;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] sum_q16;
  side_t                   side_in;

  // config port
  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
      coef[0]       <= COEF0_RESET;
      coef[1]       <= COEF1_RESET;
      coef[2]       <= '0;
      coef[3]       <= '0;
      coef[4]       <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_LENGTH: window_length <= pwdata[LEN_BITS-1:0];
        REG_COEF0:  coef[0]       <= pwdata[COEF_BITS-1:0];
        REG_COEF1:  coef[1]       <= pwdata[COEF_BITS-1:0];
        REG_COEF2:  coef[2]       <= pwdata[COEF_BITS-1:0];
        REG_COEF3:  coef[3]       <= pwdata[COEF_BITS-1:0];
        REG_COEF4:  coef[4]       <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH: prdata = DATA_BITS'(window_length);
      REG_COEF0:  prdata = DATA_BITS'(coef[0]);
      REG_COEF1:  prdata = DATA_BITS'(coef[1]);
      REG_COEF2:  prdata = DATA_BITS'(coef[2]);
      REG_COEF3:  prdata = DATA_BITS'(coef[3]);
      REG_COEF4:  prdata = DATA_BITS'(coef[4]);
      default:    prdata = '0;
    endcase
  end

  // pipeline control
  assign out_load       = !weight_ch.valid || weight_ch.ready;
  assign en             = !v[LAST] || out_load;
  assign index_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NUM_STAGES-2:0], index_ch.valid};
    end
  end

  // entry stage: numerators 2*full*k*i + d for phase = round(k*i*full/d) mod full
  assign len_less_one = window_length - LEN_BITS'(1);
  assign den          = {len_less_one, 1'b0};

  assign side_in.idx       = index_ch.sample_index;
  assign side_in.beyond    = DATA_BITS'(index_ch.sample_index) >= DATA_BITS'(window_length);
  assign side_in.short_len = window_length < LEN_BITS'(2);

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_num
    assign num_in[k] = ((DIV_NUM_BITS'(index_ch.sample_index) * DIV_NUM_BITS'(k + 1))
                        << (PHASE_BITS + 1)) + DIV_NUM_BITS'(len_less_one);
    always_ff @(posedge clk) begin
      if (en) begin
        num[k] <= num_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[STG_IN] <= side_in;
      for (int s = 1; s < NUM_STAGES; s++) begin
        side_pipe[s] <= side_pipe[s-1];
      end
    end
  end

  csw_phase_div u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .stage_valid (v[DIV_STAGES:1]),
    .num         (num),
    .den         (den),
    .phase       (phase)
  );

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_rom
    csw_cos_rom u_rom (
      .clk   (clk),
      .en    (en),
      .phase (phase[k]),
      .mag   (mag[k]),
      .zero  (zero[k]),
      .neg   (neg[k])
    );
  end

  csw_weight_sum u_sum (
    .clk       (clk),
    .en        (en),
    .mag       (mag),
    .zero      (zero),
    .neg       (neg),
    .short_len (side_pipe[STG_ROM].short_len),
    .coef      (coef),
    .sum       (sum)
  );

  // output register, round half up
  assign sum_q16 = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_ch.valid <= 1'b0;
    end else if (out_load) begin
      weight_ch.valid <= v[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && v[LAST]) begin
      weight_ch.weight              <= sum_q16[WEIGHT_BITS-1:0];
      weight_ch.index_beyond_length <= side_pipe[LAST].beyond;
      weight_ch.echo_index          <= side_pipe[LAST].idx;
    end
  end

  `CSW_ASSERT_IMPLIES(a_beyond_flag, clk, rst, weight_ch.valid,
    weight_ch.index_beyond_length ==
      (DATA_BITS'(weight_ch.echo_index) >= DATA_BITS'(window_length)))
  `CSW_ASSERT_IMPLIES(a_short_weight, clk, rst,
    weight_ch.valid && (window_length < LEN_BITS'(2)),
    weight_ch.weight == (WEIGHT_BITS'(coef[0]) - WEIGHT_BITS'(coef[1])
      + WEIGHT_BITS'(coef[2]) - WEIGHT_BITS'(coef[3]) + WEIGHT_BITS'(coef[4])))
  `CSW_ASSERT_NEXT(a_stall_holds_last, clk, rst,
    v[LAST] && weight_ch.valid && !weight_ch.ready, v[LAST])
endmodule
